>>> sv/sal_pkg.sv
`timescale 1ns / 1ps

package sal_pkg;

  // Field widths of the request and response transactions
  localparam int SET_INDEX_W = 6;
  localparam int TAG_W       = 20;
  localparam int KIND_W      = 2;
  localparam int WAY_W       = 2;

  // Default geometry
  localparam int SETS_DEF     = 64;
  localparam int WAYS_DEF     = 4;
  localparam int TAG_BITS_DEF = 20;

  typedef enum logic [KIND_W-1:0] {
    KIND_HIT      = 2'd0,
    KIND_COLD     = 2'd1,
    KIND_CONFLICT = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_DONE
  } state_t;

endpackage

>>> sv/sal_req_if.sv
`timescale 1ns / 1ps

interface sal_req_if;
  logic                              valid;
  logic                              ready;
  logic [sal_pkg::SET_INDEX_W-1:0]   set_index;
  logic [sal_pkg::TAG_W-1:0]         tag;

  modport source (output valid, output set_index, output tag, input ready);
  modport sink   (input valid, input set_index, input tag, output ready);
endinterface

>>> sv/sal_rsp_if.sv
`timescale 1ns / 1ps

interface sal_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sal_pkg::KIND_W-1:0]   access_kind;
  logic [sal_pkg::WAY_W-1:0]    way;

  modport source (output valid, output access_kind, output way, input ready);
  modport sink   (input valid, input access_kind, input way, output ready);
endinterface

>>> sv/sal_ram.sv
`timescale 1ns / 1ps

module sal_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/sal_lru.sv
`timescale 1ns / 1ps

// Move-to-front of one way in a recency list (entry 0 = most recent).
module sal_lru #(
  parameter int WAYS = 4
) (
  input  logic [WAYS-1:0][((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] order_in,
  input  logic [((WAYS > 1) ? $clog2(WAYS) : 1)-1:0]           mru_way,
  output logic [WAYS-1:0][((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] order_out
);

  logic [WAYS-1:0] match;
  logic [WAYS-1:0] at_or_after;
  logic            any_match;

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      match[i] = (order_in[i] == mru_way);
    end
    any_match = |match;
    // at_or_after[i]: the way sits at position i or later
    at_or_after[WAYS-1] = match[WAYS-1];
    for (int i = WAYS - 2; i >= 0; i--) begin
      at_or_after[i] = at_or_after[i+1] | match[i];
    end
  end

  always_comb begin
    order_out[0] = mru_way;
    for (int i = 1; i < WAYS; i++) begin
      // absent way behaves as if it sat in the last slot
      if (at_or_after[i] || !any_match) begin
        order_out[i] = order_in[i-1];
      end else begin
        order_out[i] = order_in[i];
      end
    end
  end

endmodule

>>> sv/set_assoc_lru_tag_lookup_top.sv
`timescale 1ns / 1ps
// Sequence: IDLE accepts a request, REDUCE wraps its index, SCAN compares the ways in turn;
//   a hit stops the scan early, a miss goes through DECIDE; then UPDATE and DONE follow.
//   With SETS below 64, REDUCE subtracts SETS from the index until it is below SETS.
// Flow: one request at a time (ready only in IDLE), one tag compare per cycle in SCAN.
// Reset: after rst a clearing pass writes every set's state row;
//   no request is accepted until it ends.
module set_assoc_lru_tag_lookup_top #(
  parameter int SETS     = sal_pkg::SETS_DEF,
  parameter int WAYS     = sal_pkg::WAYS_DEF,
  parameter int TAG_BITS = sal_pkg::TAG_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  sal_req_if.sink   req,
  sal_rsp_if.source rsp
);

  import sal_pkg::*;

  localparam int WB        = (WAYS > 1) ? $clog2(WAYS) : 1;   // way number width
  localparam int SAW       = (SETS > 1) ? $clog2(SETS) : 1;   // set address width
  localparam int ROW_W     = WAYS + WAYS * WB;                // {order, valid}
  localparam int TAG_DEPTH = SETS * (2 ** WB);                // addressed as {set, way}
  localparam int TAW       = SAW + WB;

  typedef logic [WAYS-1:0][WB-1:0] order_t;

  // Sequencer and work registers
  state_t                 state, state_next;
  logic [SET_INDEX_W-1:0] idx;
  logic [TAG_BITS-1:0]    tag_q;
  logic [WB-1:0]          way_cnt;
  logic                   has_inv;
  logic [WB-1:0]          inv_way;
  kind_t                  kind;
  logic [WB-1:0]          chosen;
  logic [SAW-1:0]         clr_cnt;

  // Response holding register
  logic                   out_valid;
  kind_t                  out_kind;
  logic [WAY_W-1:0]       out_way;

  // Memory ports
  logic                   row_we;
  logic [SAW-1:0]         row_waddr;
  logic [ROW_W-1:0]       row_wdata;
  logic [ROW_W-1:0]       row_rd;
  logic                   tag_we;
  logic [TAW-1:0]         tag_waddr;
  logic [TAW-1:0]         tag_raddr;
  logic [TAG_BITS-1:0]    tag_rd;

  logic [SAW-1:0]         set_addr;
  logic [WB-1:0]          way_rd;
  logic [WAYS-1:0]        valid_rd;
  order_t                 order_rd;
  order_t                 order_new;
  order_t                 order_init;
  logic [WAYS-1:0]        valid_new;
  logic                   idx_wrap;
  logic                   hit;
  logic                   scan_last;
  logic                   out_free;

  assign set_addr  = SAW'(idx);
  assign valid_rd  = row_rd[WAYS-1:0];
  assign order_rd  = order_t'(row_rd[ROW_W-1:WAYS]);
  assign idx_wrap  = (int'(idx) >= SETS);
  assign scan_last = (way_cnt == WB'(WAYS - 1));
  // the single shared compare: one way per cycle
  assign hit       = valid_rd[way_cnt] && (tag_rd == tag_q);
  assign out_free  = !out_valid || rsp.ready;

  // Per-set state row: valid bits and recency list
  sal_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (set_addr),
    .rdata (row_rd)
  );

  // Tag store; read address runs one way ahead so data lines up with way_cnt
  sal_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (TAG_DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_q),
    .raddr (tag_raddr),
    .rdata (tag_rd)
  );

  sal_lru #(
    .WAYS (WAYS)
  ) u_lru (
    .order_in  (order_rd),
    .mru_way   (chosen),
    .order_out (order_new)
  );

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      order_init[i] = WB'(i);
      valid_new[i]  = valid_rd[i] | (WB'(i) == chosen);
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == SAW'(SETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (!idx_wrap) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit) begin
          state_next = ST_UPDATE;
        end else if (scan_last) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: state_next = ST_UPDATE;
      ST_UPDATE: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_CLEAR;
    endcase
  end

  // Datapath controls
  always_comb begin
    req.ready = 1'b0;
    row_we    = 1'b0;
    row_waddr = set_addr;
    row_wdata = {order_new, valid_new};
    tag_we    = 1'b0;
    tag_waddr = {set_addr, chosen};
    way_rd    = '0;
    case (state)
      ST_CLEAR: begin
        row_we    = 1'b1;
        row_waddr = clr_cnt;
        row_wdata = {order_init, {WAYS{1'b0}}};
      end
      ST_IDLE: req.ready = 1'b1;
      ST_SCAN: begin
        if (!scan_last) begin
          way_rd = way_cnt + WB'(1);
        end
      end
      ST_UPDATE: begin
        row_we = 1'b1;
        tag_we = (kind != KIND_HIT);
      end
      default: ;
    endcase
  end

  assign tag_raddr = {set_addr, way_rd};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: clr_cnt <= clr_cnt + SAW'(1);
        ST_IDLE: begin
          idx     <= req.set_index;
          tag_q   <= TAG_BITS'(req.tag);
          way_cnt <= '0;
          has_inv <= 1'b0;
        end
        ST_REDUCE: begin
          // index wraps modulo SETS
          if (idx_wrap) begin
            idx <= idx - SET_INDEX_W'(SETS);
          end
        end
        ST_SCAN: begin
          if (!valid_rd[way_cnt] && !has_inv) begin
            has_inv <= 1'b1;
            inv_way <= way_cnt;
          end
          if (hit) begin
            kind   <= KIND_HIT;
            chosen <= way_cnt;
          end
          way_cnt <= way_cnt + WB'(1);
        end
        ST_DECIDE: begin
          if (has_inv) begin
            kind   <= KIND_COLD;
            chosen <= inv_way;
          end else begin
            kind   <= KIND_CONFLICT;
            chosen <= order_rd[WAYS-1];
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_kind  <= kind;
            out_way   <= WAY_W'(chosen);
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.access_kind = out_kind;
  assign rsp.way         = out_way;

endmodule

>>> sim/tb_set_assoc_lru_tag_lookup_top.sv
`timescale 1ns / 1ps

// Directed and random access streams into the LRU tag store, checked against a
// behavioral copy of the tag/valid/recency state kept in the bench.
module tb_set_assoc_lru_tag_lookup_top;
  import sal_pkg::*;

  localparam int SETS        = SETS_DEF;
  localparam int WAYS        = WAYS_DEF;
  localparam int TAG_BITS    = TAG_BITS_DEF;
  localparam int MAX_GAP     = 18;
  localparam int LONG_HOLD   = 300;        // receiver hold-off for the backpressure test
  localparam int DRAIN_WAIT  = 4 * (5 + WAYS);
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 600;

  // one predicted response transaction
  typedef struct packed {
    kind_t            kind;
    logic [WAY_W-1:0] way;
  } lookup_result_t;

  logic clk;
  logic rst;

  sal_req_if req_ch ();
  sal_rsp_if rsp_ch ();

  set_assoc_lru_tag_lookup_top #(
    .SETS     (SETS),
    .WAYS     (WAYS),
    .TAG_BITS (TAG_BITS)
  ) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Bench copy of the cache state: valid bits, tags and the per-set recency
  // list, most recent first.
  logic                 shadow_valid [SETS][WAYS];
  logic [TAG_W-1:0]     shadow_tag   [SETS][WAYS];
  logic [WAY_W-1:0]     shadow_order [SETS][WAYS];

  lookup_result_t pending_results[$];

  int unsigned errors;
  int unsigned accesses_sent;
  int unsigned hits_seen;
  int unsigned colds_seen;
  int unsigned conflicts_seen;
  int unsigned holds_done;
  int unsigned cycle_count;

  // traffic shaping: zero_idle for the sender and the receiver, hold_request for the receiver
  bit zero_idle;
  bit hold_request;

  // --------------------------------------------------------------------------
  // Clock and cycle watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d responses outstanding",
               $time, cycle_count, pending_results.size());
      $display("tb_set_assoc_lru_tag_lookup_top: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  task automatic clear_shadow();
    for (int s = 0; s < SETS; s++) begin
      for (int w = 0; w < WAYS; w++) begin
        shadow_valid[s][w] = 1'b0;
        shadow_tag[s][w]   = '0;
        shadow_order[s][w] = WAY_W'(w);
      end
    end
  endtask

  // Hit on a matching valid way; else fill the lowest invalid way; else evict
  // the tail of the recency list. The chosen way moves to the head.
  function automatic lookup_result_t predict_lookup(input logic [SET_INDEX_W-1:0] s,
                                                    input logic [TAG_W-1:0] t);
    lookup_result_t r;
    int hit_way;
    int free_way;
    int pos;
    hit_way  = -1;
    free_way = -1;
    for (int w = 0; w < WAYS; w++) begin
      if (hit_way < 0 && shadow_valid[s][w] && shadow_tag[s][w] == t) hit_way = w;
      if (free_way < 0 && !shadow_valid[s][w]) free_way = w;
    end
    if (hit_way >= 0) begin
      r.kind = KIND_HIT;
      r.way  = WAY_W'(hit_way);
    end else if (free_way >= 0) begin
      r.kind = KIND_COLD;
      r.way  = WAY_W'(free_way);
    end else begin
      r.kind = KIND_CONFLICT;
      r.way  = shadow_order[s][WAYS-1];
    end
    if (r.kind != KIND_HIT) begin
      shadow_valid[s][r.way] = 1'b1;
      shadow_tag[s][r.way]   = t;
    end
    // locate the chosen way in the list, then shift the entries above it down
    pos = WAYS - 1;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (shadow_order[s][i] == r.way) pos = i;
    end
    while (pos > 0) begin
      shadow_order[s][pos] = shadow_order[s][pos-1];
      pos--;
    end
    shadow_order[s][0] = r.way;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request sender: entered and left at a falling edge. A zero gap keeps valid
  // high straight into the next transaction.
  // --------------------------------------------------------------------------
  task automatic issue_access(input logic [SET_INDEX_W-1:0] s, input logic [TAG_W-1:0] t);
    int unsigned gap;
    gap = zero_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.set_index <= s;
    req_ch.tag       <= t;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_results.push_back(predict_lookup(s, t));
    accesses_sent++;
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Response receiver: draws a stall before each transaction; a hold request
  // from the backpressure test turns one stall into a long hold-off.
  // --------------------------------------------------------------------------
  initial begin : rsp_drain
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_request) begin
        stall        = LONG_HOLD;
        hold_request = 1'b0;
        holds_done++;
      end else if (zero_idle) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(rsp_ch.valid && rsp_ch.ready)) @(posedge clk);
      @(negedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Response checker: every accepted response against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : rsp_check
    lookup_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: response with nothing expected: kind %0d way %0d",
                 $time, rsp_ch.access_kind, rsp_ch.way);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.access_kind !== want.kind) begin
          $display("%0t: access_kind mismatch: expected %0d actual %0d",
                   $time, want.kind, rsp_ch.access_kind);
          errors++;
        end
        if (rsp_ch.way !== want.way) begin
          $display("%0t: way mismatch: expected %0d actual %0d",
                   $time, want.way, rsp_ch.way);
          errors++;
        end
        case (want.kind)
          KIND_HIT:  hits_seen++;
          KIND_COLD: colds_seen++;
          default:   conflicts_seen++;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Empty sets: each new tag takes the lowest invalid way; extreme tags and
  // both end sets.
  task automatic test_cold_fill();
    issue_access(6'd0,  20'h00000);
    issue_access(6'd0,  20'hFFFFF);
    issue_access(6'd0,  20'h55555);
    issue_access(6'd0,  20'hAAAAA);
    issue_access(6'd63, 20'hFFFFF);
    issue_access(6'd63, 20'h00000);
  endtask

  // Hits in the full set 0, reordering the recency list, and a hit in set 63.
  task automatic test_hit_recency();
    issue_access(6'd0,  20'h00000);
    issue_access(6'd0,  20'hAAAAA);
    issue_access(6'd0,  20'h55555);
    issue_access(6'd0,  20'hFFFFF);
    issue_access(6'd63, 20'hFFFFF);
  endtask

  // Full set 0: new tags evict the least recently used way; set 63 still takes a cold fill.
  task automatic test_conflict_eviction();
    issue_access(6'd0,  20'h12345);
    issue_access(6'd0,  20'h00000);
    issue_access(6'd0,  20'h12345);
    issue_access(6'd0,  20'hEDCBA);
    issue_access(6'd63, 20'h00001);
  endtask

  // Back-to-back accesses, nearly all to one set, with no idling on either side.
  task automatic test_back_to_back();
    zero_idle = 1'b1;
    issue_access(6'd5, 20'h00007);
    issue_access(6'd5, 20'h00007);
    issue_access(6'd5, 20'h00008);
    issue_access(6'd5, 20'h00009);
    issue_access(6'd5, 20'h0000A);
    issue_access(6'd5, 20'h0000B);
    issue_access(6'd5, 20'h00007);
    issue_access(6'd6, 20'h00007);
    zero_idle = 1'b0;
  endtask

  // Receiver holds off for a long stretch while requests keep coming, so the
  // block backs up and drops req.ready.
  task automatic test_receiver_hold();
    @(posedge clk);
    hold_request = 1'b1;
    @(negedge clk);
    zero_idle = 1'b1;
    for (int i = 0; i < 12; i++) issue_access(6'd9, TAG_W'(i % 6));
    zero_idle = 1'b0;
  endtask

  // Mostly a few hot sets and a small tag pool so hits and conflicts are
  // frequent; the rest fully random. Periodic stretches with no idling.
  task automatic test_random_traffic(input int unsigned count);
    logic [SET_INDEX_W-1:0] hot_sets [4];
    logic [TAG_W-1:0]       tag_pool [6];
    logic [SET_INDEX_W-1:0] s;
    logic [TAG_W-1:0]       t;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 100 == 0) begin
        foreach (hot_sets[k]) hot_sets[k] = SET_INDEX_W'($urandom_range(0, SETS - 1));
        foreach (tag_pool[k]) tag_pool[k] = TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
      end
      zero_idle = ((i % 150) >= 110);
      if ($urandom_range(0, 9) < 7) begin
        s = hot_sets[$urandom_range(0, 3)];
        t = tag_pool[$urandom_range(0, 5)];
      end else begin
        s = SET_INDEX_W'($urandom_range(0, SETS - 1));
        t = TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
      end
      issue_access(s, t);
    end
    zero_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    errors         = 0;
    accesses_sent  = 0;
    hits_seen      = 0;
    colds_seen     = 0;
    conflicts_seen = 0;
    holds_done     = 0;
    cycle_count    = 0;
    zero_idle      = 1'b0;
    hold_request   = 1'b0;
    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.set_index = '0;
    req_ch.tag       = '0;
    clear_shadow();

    // synchronous reset; the block's clearing pass holds req.ready low after
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    test_cold_fill();
    test_hit_recency();
    test_conflict_eviction();
    test_back_to_back();
    test_receiver_hold();
    test_random_traffic(RANDOM_ITEMS);

    req_ch.valid <= 1'b0;

    // drain, then leave room for any stray response
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("ran %0d accesses: %0d hits, %0d cold fills, %0d conflict evictions",
             accesses_sent, hits_seen, colds_seen, conflicts_seen);
    $display("with random idling on both sides and %0d long receiver hold-off(s)",
             holds_done);
    if (errors == 0) begin
      $display("tb_set_assoc_lru_tag_lookup_top: clean");
    end else begin
      $display("tb_set_assoc_lru_tag_lookup_top: errors");
    end
    $finish;
  end

endmodule
